FILE: hw/rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg - shared types and constants for the double press confirmer
// Phase encodings, configuration register indexes and the result word.
// ----------------------------------------------------------------------------
package dpc_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int DUR_W          = 31;
	localparam int NOW_W          = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	// timer slots
	localparam int T_FIRST   = 0;
	localparam int T_SECOND  = 1;
	localparam int T_TIMEOUT = 2;
	localparam int N_TIMERS  = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

	// phase codes as seen on the result word
	localparam logic [1:0] PHASE_WAIT_FIRST  = 2'd0;
	localparam logic [1:0] PHASE_WAIT_REL    = 2'd1;
	localparam logic [1:0] PHASE_WAIT_SECOND = 2'd2;
	localparam logic [1:0] PHASE_CONFIRMED   = 2'd3;

	typedef enum logic [3:0] {
		PH_WAIT_FIRST  = 4'b0001,
		PH_WAIT_REL    = 4'b0010,
		PH_WAIT_SECOND = 4'b0100,
		PH_CONFIRMED   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [DUR_W-1:0] first_hold;
		logic [DUR_W-1:0] second_hold;
		logic [DUR_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic       confirmed;
		logic       past_first_press;
		logic [1:0] phase;
	} res_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_WAIT_FIRST:  code = PHASE_WAIT_FIRST;
			PH_WAIT_REL:    code = PHASE_WAIT_REL;
			PH_WAIT_SECOND: code = PHASE_WAIT_SECOND;
			PH_CONFIRMED:   code = PHASE_CONFIRMED;
			default:        code = PHASE_WAIT_FIRST;
		endcase
		return code;
	endfunction

endpackage

FILE: hw/rtl/dpc_timer.sv
// ----------------------------------------------------------------------------
// dpc_timer - timer expiry check
// Expired when running and the wrapped elapsed time reaches the duration.
// ----------------------------------------------------------------------------
module dpc_timer import dpc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  running,
	input  logic [TIME_WIDTH-1:0] start,
	input  logic [TIME_WIDTH-1:0] now,
	input  logic [DUR_W-1:0]      dur,
	output logic                  expired
);

	localparam int CMP_W = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

	logic [TIME_WIDTH-1:0] elapsed;

	assign elapsed = now - start;
	assign expired = running && (CMP_W'(elapsed) >= CMP_W'(dur));

endmodule

FILE: hw/rtl/dpc_fsm.sv
// ----------------------------------------------------------------------------
// dpc_fsm - phase machine and timers
// Takes one word per enabled cycle, updates phase, edge and timer state and
// gives the result word for the new state.
// ----------------------------------------------------------------------------
module dpc_fsm import dpc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  sample,
	input  logic [TIME_WIDTH-1:0] now,
	input  cfg_t                  cfg,
	output res_t                  res_d,
	output logic [1:0]            phase_cur
);

	phase_t                phase_q, phase_d;
	logic                  last_q;
	logic                  run_q     [N_TIMERS];
	logic [TIME_WIDTH-1:0] start_q   [N_TIMERS];
	logic                  run_eff   [N_TIMERS];
	logic [TIME_WIDTH-1:0] start_eff [N_TIMERS];
	logic                  run_d     [N_TIMERS];
	logic [DUR_W-1:0]      dur       [N_TIMERS];
	logic [N_TIMERS-1:0]   expd;
	logic                  rising;

	assign rising = sample && !last_q;
	assign dur[T_FIRST]   = cfg.first_hold;
	assign dur[T_SECOND]  = cfg.second_hold;
	assign dur[T_TIMEOUT] = cfg.timeout;

	// timer (re)starts and stops of this word, seen by the expiry checks
	always_comb begin
		run_eff   = run_q;
		start_eff = start_q;
		case (phase_q)
			PH_WAIT_FIRST: begin
				if (rising) begin
					run_eff[T_FIRST]   = 1'b1;
					start_eff[T_FIRST] = now;
				end
			end
			PH_WAIT_REL: begin
				if (!sample) begin
					run_eff[T_TIMEOUT]   = 1'b1;
					start_eff[T_TIMEOUT] = now;
				end
			end
			PH_WAIT_SECOND: begin
				if (!sample)
					run_eff[T_SECOND] = 1'b0;
				if (rising) begin
					run_eff[T_SECOND]   = 1'b1;
					start_eff[T_SECOND] = now;
				end
			end
			default: ;
		endcase
	end

	for (genvar k = 0; k < N_TIMERS; k++) begin : g_tmr
		dpc_timer #(.TIME_WIDTH(TIME_WIDTH)) u_tmr (
			.running (run_eff[k]),
			.start   (start_eff[k]),
			.now     (now),
			.dur     (dur[k]),
			.expired (expd[k])
		);
	end

	always_comb begin
		phase_d = phase_q;
		run_d   = run_eff;
		case (phase_q)
			PH_WAIT_FIRST: begin
				if (expd[T_FIRST] && sample) begin
					phase_d        = PH_WAIT_REL;
					run_d[T_FIRST] = 1'b0;
				end
			end
			PH_WAIT_REL: begin
				if (!sample)
					phase_d = PH_WAIT_SECOND;
			end
			PH_WAIT_SECOND: begin
				if (expd[T_SECOND]) begin
					phase_d         = PH_CONFIRMED;
					run_d[T_SECOND] = 1'b0;
				end
				// timeout wins
				if (expd[T_TIMEOUT]) begin
					phase_d         = PH_WAIT_FIRST;
					run_d[T_SECOND] = 1'b0;
				end
			end
			PH_CONFIRMED: begin
				if (!sample)
					phase_d = PH_WAIT_FIRST;
			end
			default: phase_d = PH_WAIT_FIRST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_FIRST;
			last_q  <= 1'b0;
			for (int k = 0; k < N_TIMERS; k++)
				run_q[k] <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			last_q  <= sample;
			run_q   <= run_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			start_q <= start_eff;
	end

	assign res_d.confirmed        = (phase_d == PH_CONFIRMED);
	assign res_d.past_first_press = (phase_d != PH_WAIT_FIRST);
	assign res_d.phase            = phase_code(phase_d);
	assign phase_cur              = phase_code(phase_q);

endmodule

FILE: hw/rtl/double_press_confirm.sv
// ----------------------------------------------------------------------------
// double_press_confirm - press, release, second press confirmation
// Top level: configuration registers, input register and result register
// around the phase machine.
// ----------------------------------------------------------------------------
// One word can be taken every clock cycle while the input is not stalled, and
// each gives exactly one result word, valid on the outputs once it has passed
// the input register and then the result register. The rate is set by the
// combinational phase and timer update between those registers. The input
// stalls only while both registers hold a word and the result word is itself
// stalled. Timer durations are written through the configuration port, which
// is always ready; write it only while no word is in flight.
module double_press_confirm import dpc_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  sample,
	input  logic [NOW_W-1:0]      now_us,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  confirmed,
	output logic                  past_first_press,
	output logic [1:0]            phase
);

	cfg_t                  cfg_q;
	logic                  valid_s1;
	logic                  sample_s1;
	logic [NOW_W-1:0]      now_s1;
	logic                  out_valid_q;
	res_t                  res_q;
	res_t                  res_d;
	logic                  adv;
	logic                  proc;
	logic [TIME_WIDTH-1:0] now_tw;
	logic [1:0]            phase_cur;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_HOLD:  cfg_q.first_hold  <= cfg_data[DUR_W-1:0];
				CFG_SECOND_HOLD: cfg_q.second_hold <= cfg_data[DUR_W-1:0];
				CFG_TIMEOUT:     cfg_q.timeout     <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign proc     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
			now_s1    <= now_us;
		end
		if (proc)
			res_q <= res_d;
	end

	assign now_tw = TIME_WIDTH'(now_s1);

	dpc_fsm #(.TIME_WIDTH(TIME_WIDTH)) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (proc),
		.sample    (sample_s1),
		.now       (now_tw),
		.cfg       (cfg_q),
		.res_d     (res_d),
		.phase_cur (phase_cur)
	);

	assign out_valid        = out_valid_q;
	assign confirmed        = res_q.confirmed;
	assign past_first_press = res_q.past_first_press;
	assign phase            = res_q.phase;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with free pipeline");

	a_confirmed_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && phase_cur == PHASE_CONFIRMED) |=>
		(phase_cur == PHASE_CONFIRMED || phase_cur == PHASE_WAIT_FIRST))
		else $error("illegal exit from confirmed phase");

	a_first_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && phase_cur == PHASE_WAIT_FIRST) |=>
		(phase_cur == PHASE_WAIT_FIRST || phase_cur == PHASE_WAIT_REL))
		else $error("phase skipped from waiting for first press");

	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		$past(proc) |-> (phase == phase_cur))
		else $error("result word does not follow phase");

endmodule
